[rtl/eptw_pkg.sv]
// Shared types, codes and constants of the eased position tween.
// Holds the divider request and response structs and the quarter-sine entry function.
// Used by every module of the block; depends on nothing else.
package eptw_pkg;

  // Default number of table steps over a quarter turn.
  localparam int SINE_TABLE_DEPTH = 256;

  // Field widths.
  localparam int POS_W   = 24;
  localparam int SPAN_W  = POS_W + 1;
  localparam int TIME_W  = 16;
  localparam int PROG_W  = 17;
  localparam int MUL_A_W = SPAN_W;
  localparam int MUL_B_W = PROG_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Progress of one whole move in Q1.16.
  localparam logic [PROG_W-1:0] ONE_Q16 = 17'h10000;

  // pi / 2 in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Item kinds on the input tuser.
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_SET_POS  = 2'd1;
  localparam logic [1:0] FUNC_SET_ZOOM = 2'd2;

  // Easing curves.
  localparam logic [1:0] MODE_SINE   = 2'd0;
  localparam logic [1:0] MODE_COSINE = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic CFG_MOVE_DURATION = 1'b0;
  localparam logic CFG_EASE_MODE     = 1'b1;
  localparam logic [TIME_W-1:0] DURATION_RESET = 16'd60;
  localparam logic [1:0]        MODE_RESET     = MODE_LINEAR;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quo;
  } div_rsp_t;

  // Sine of a Q30 angle by a Taylor series up to the fifteenth power, rounded to Q16.
  // Only ever evaluated while the design is elaborated.
  function automatic logic [PROG_W-1:0] sine_q16(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = ($unsigned(sum) + 64'd8192) >> 14;
    if (q > 64'd65536) begin
      q = 64'd65536;
    end
    return q[PROG_W-1:0];
  endfunction

endpackage

[rtl/eptw_divider.sv]
// Restoring divider giving floor(num * 2^16 / den) one quotient bit per cycle.
// The dividend must be below the divisor. Depends on eptw_pkg.
module eptw_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eptw_pkg::div_req_t  req_i,
  output eptw_pkg::div_rsp_t  rsp_o
);
  import eptw_pkg::*;

  localparam int CntW = $clog2(TIME_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] den_q;
  logic [TIME_W-1:0] quo_q;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   trial;
  logic              fits;

  // The partial remainder stays below the divisor, so it fits in 16 bits after a subtract.
  assign shifted = {rem_q, 1'b0};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(TIME_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(TIME_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo_q <= {quo_q[TIME_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[rtl/eptw_sine_rom.sv]
// Quarter-sine table in Q16 with a registered read port.
// Entries are worked out during elaboration with eptw_pkg::sine_q16.
module eptw_sine_rom #(
  parameter int Depth = eptw_pkg::SINE_TABLE_DEPTH,
  localparam int AddrW = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic [AddrW-1:0]            addr_i,
  output logic [eptw_pkg::PROG_W-1:0] data_o
);
  import eptw_pkg::*;

  logic [PROG_W-1:0] rom [Depth+1];
  logic [PROG_W-1:0] data_q;

  for (genvar k = 0; k <= Depth; k++) begin : g_entry
    localparam logic [63:0]       Angle = (64'(k) * HALF_PI_Q30) / 64'(Depth);
    localparam logic [PROG_W-1:0] Value = sine_q16(Angle);
    assign rom[k] = Value;
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

[rtl/eased_position_tween.sv]
// Top level of the eased position tween: sequencer, shared multiplier and axis state.
// Depends on eptw_pkg, eptw_divider and eptw_sine_rom.
//
//  Channel  | Direction | Carries
//  ---------+-----------+----------------------------------------------------------
//  s_axis   | in        | tuser: func; tdata: tick_delta, goal_x, goal_y, goal_zoom
//  m_axis   | out       | tuser: in_motion; tdata: pos_x, pos_y, zoom_level
//  cfg      | in        | index 0 move_duration, index 1 ease_mode
//
// A command, an unused kind or a tick while at rest goes from the idle state straight
// to the output state. A tick during a move runs the serial divider for the progress,
// then the table lookup, whose index and interpolation also use the shared 25 by 17
// multiplier, then three passes of that multiplier, one per axis. A finished move skips
// the divider and the linear curve skips the table. One item is in work at a time.
// Reset gives a duration of 60 ticks, the linear curve, every axis at zero and the
// motion flag set. A result waits in the output register while the next item is taken;
// a further result waits in its own state until the output side frees.
module eased_position_tween #(
  parameter int SineTableDepth = eptw_pkg::SINE_TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [87:0]                   s_axis_tdata,  // tick_delta, goal_x, goal_y, goal_zoom
  input  logic [1:0]                    s_axis_tuser,  // func
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata,  // pos_x, pos_y, zoom_level
  output logic [0:0]                    m_axis_tuser,  // in_motion
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [eptw_pkg::TIME_W-1:0]   cfg_data_i
);
  import eptw_pkg::*;

  localparam int IdxW = $clog2(SineTableDepth + 1);
  localparam int NumAxes = 3;
  localparam logic [1:0] AXIS_LAST = 2'(NumAxes - 1);
  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_EASE  = 10'b0000000100,
    S_IDX   = 10'b0000001000,
    S_ROMA  = 10'b0000010000,
    S_ROMB  = 10'b0000100000,
    S_LERP  = 10'b0001000000,
    S_AXMUL = 10'b0010000000,
    S_AXACC = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  // Difference of two Q16.8 values, one bit wider.
  function automatic logic [SPAN_W-1:0] span_of(input logic [POS_W-1:0] aim,
                                                input logic [POS_W-1:0] cur);
    return {aim[POS_W-1], aim} - {cur[POS_W-1], cur};
  endfunction

  state_e state_q, state_d;

  // Configuration.
  logic [TIME_W-1:0] dur_q;
  logic [1:0]        mode_q;

  // Axis state: X, Y and zoom.
  logic [POS_W-1:0]  cur_q   [NumAxes];
  logic [POS_W-1:0]  start_q [NumAxes];
  logic [POS_W-1:0]  aim_q   [NumAxes];
  logic [SPAN_W-1:0] span_q  [NumAxes];
  logic [TIME_W-1:0] elapsed_q;
  logic              moving_q;
  logic [1:0]        axis_q;

  // Datapath registers.
  logic [PROG_W-1:0]  p_q;
  logic [PROG_W-1:0]  f_q;
  logic [IdxW-1:0]    idx_q;
  logic               top_q;
  logic [15:0]        frac_q;
  logic [PROG_W-1:0]  a_q;
  logic [MUL_P_W-1:0] mul_q;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // Output register.
  logic              out_valid_q;
  logic [71:0]       out_data_q;
  logic              out_motion_q;
  logic              out_load;

  // Input fields.
  logic              in_fire;
  logic [1:0]        in_func;
  logic [TIME_W-1:0] in_delta;
  logic [POS_W-1:0]  in_goal_x;
  logic [POS_W-1:0]  in_goal_y;
  logic [POS_W-1:0]  in_goal_zoom;

  logic [TIME_W:0]    el_sum;
  logic [TIME_W-1:0]  el_new;
  logic               p_one;
  logic               ease_curve;
  logic [PROG_W-1:0]  ease_q;
  logic [IdxW-1:0]    mul_idx;
  logic [IdxW-1:0]    rom_addr;
  logic [PROG_W-1:0]  rom_data;
  logic [PROG_W-1:0]  lerp_diff;
  logic [PROG_W-1:0]  lerp_sum;
  logic [PROG_W-1:0]  f_lerp;
  logic [SPAN_W-1:0]  span_sel;
  logic               span_neg;
  logic [SPAN_W-1:0]  span_mag;
  logic [MUL_P_W-1:0] mul_rnd;
  logic [POS_W-1:0]   prod_lo;
  logic [POS_W-1:0]   axis_new;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign in_func      = s_axis_tuser;
  assign in_delta     = s_axis_tdata[15:0];
  assign in_goal_x    = s_axis_tdata[39:16];
  assign in_goal_y    = s_axis_tdata[63:40];
  assign in_goal_zoom = s_axis_tdata[87:64];

  assign s_axis_tready = (state_q == S_IDLE);

  // Elapsed time saturates at its maximum; a zero duration counts as a finished move.
  assign el_sum = {1'b0, elapsed_q} + {1'b0, in_delta};
  assign el_new = el_sum[TIME_W] ? {TIME_W{1'b1}} : el_sum[TIME_W-1:0];
  assign p_one  = (dur_q == '0) || (el_new >= dur_q);

  // The one-minus-cosine curve reads the sine table mirrored about the end of the move.
  assign ease_curve = (mode_q == MODE_SINE) || (mode_q == MODE_COSINE);
  assign ease_q     = (mode_q == MODE_COSINE) ? ONE_Q16 - p_q : p_q;
  assign mul_idx    = mul_q[16 +: IdxW];

  // Linear interpolation between neighbouring entries; a falling or flat pair, or the
  // last entry, leaves the first value as it is.
  assign lerp_diff = (top_q || (rom_data <= a_q)) ? '0 : rom_data - a_q;
  assign lerp_sum  = a_q + mul_q[32:16];
  assign f_lerp    = (mode_q == MODE_SINE) ? lerp_sum : ONE_Q16 - lerp_sum;

  // Each axis: start plus the span scaled by the curve, rounded half away from zero.
  assign span_sel = span_q[axis_q];
  assign span_neg = span_sel[SPAN_W-1];
  assign span_mag = span_neg ? -span_sel : span_sel;
  assign mul_rnd  = mul_q + MUL_P_W'(32768);
  assign prod_lo  = mul_rnd[16 +: POS_W];
  assign axis_new = span_neg ? start_q[axis_q] - prod_lo : start_q[axis_q] + prod_lo;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  eptw_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  eptw_sine_rom #(
    .Depth (SineTableDepth)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // Sequencer and the operand selection of the shared multiplier.
  always_comb begin
    state_d       = state_q;
    mul_a         = '0;
    mul_b         = '0;
    rom_addr      = idx_q;
    div_req.start = 1'b0;
    div_req.num   = el_new;
    div_req.den   = dur_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FUNC_TICK: begin
              if (!moving_q) begin
                state_d = S_OUT;
              end else if (p_one) begin
                state_d = S_EASE;
              end else begin
                div_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_EASE;
        end
      end
      S_EASE: begin
        if (ease_curve) begin
          mul_a   = MUL_A_W'(ease_q);
          mul_b   = MUL_B_W'(SineTableDepth);
          state_d = S_IDX;
        end else begin
          state_d = S_AXMUL;
        end
      end
      S_IDX: begin
        rom_addr = mul_idx;
        state_d  = S_ROMA;
      end
      S_ROMA: begin
        rom_addr = top_q ? idx_q : idx_q + IdxW'(1);
        state_d  = S_ROMB;
      end
      S_ROMB: begin
        mul_a   = MUL_A_W'(lerp_diff);
        mul_b   = {1'b0, frac_q};
        state_d = S_LERP;
      end
      S_LERP: state_d = S_AXMUL;
      S_AXMUL: begin
        mul_a   = span_mag;
        mul_b   = f_q;
        state_d = S_AXACC;
      end
      S_AXACC: state_d = (axis_q == AXIS_LAST) ? S_OUT : S_AXMUL;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control, configuration and axis state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dur_q       <= DURATION_RESET;
      mode_q      <= MODE_RESET;
      elapsed_q   <= '0;
      moving_q    <= 1'b1;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        cur_q[i]   <= '0;
        start_q[i] <= '0;
        aim_q[i]   <= '0;
        span_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MOVE_DURATION: dur_q  <= cfg_data_i;
          CFG_EASE_MODE:     mode_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (in_func)
              FUNC_TICK: elapsed_q <= el_new;
              FUNC_SET_POS: begin
                // A new position target restarts all three axes from where they stand.
                aim_q[AxisX]  <= in_goal_x;
                aim_q[AxisY]  <= in_goal_y;
                span_q[AxisX] <= span_of(in_goal_x, cur_q[AxisX]);
                span_q[AxisY] <= span_of(in_goal_y, cur_q[AxisY]);
                span_q[AxisZ] <= span_of(aim_q[AxisZ], cur_q[AxisZ]);
                for (int i = 0; i < NumAxes; i++) begin
                  start_q[i] <= cur_q[i];
                end
                elapsed_q <= '0;
                moving_q  <= 1'b1;
              end
              FUNC_SET_ZOOM: begin
                aim_q[AxisZ]  <= in_goal_zoom;
                span_q[AxisX] <= span_of(aim_q[AxisX], cur_q[AxisX]);
                span_q[AxisY] <= span_of(aim_q[AxisY], cur_q[AxisY]);
                span_q[AxisZ] <= span_of(in_goal_zoom, cur_q[AxisZ]);
                for (int i = 0; i < NumAxes; i++) begin
                  start_q[i] <= cur_q[i];
                end
                elapsed_q <= '0;
                moving_q  <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_AXACC: begin
          cur_q[axis_q] <= axis_new;
          if (axis_q == AXIS_LAST) begin
            axis_q <= '0;
            if (p_q == ONE_Q16) begin
              moving_q <= 1'b0;
            end
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers and the shared multiplier.
  always_ff @(posedge clk_i) begin
    mul_q <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
    case (state_q)
      S_IDLE: p_q <= ONE_Q16;
      S_DIV: begin
        if (div_rsp.done) begin
          p_q <= {1'b0, div_rsp.quo};
        end
      end
      S_EASE: f_q <= p_q;
      S_IDX: begin
        idx_q  <= mul_idx;
        top_q  <= (mul_idx == IdxW'(SineTableDepth));
        frac_q <= mul_q[15:0];
      end
      S_ROMA: a_q <= rom_data;
      S_LERP: f_q <= f_lerp;
      default: ;
    endcase
    if (out_load) begin
      out_data_q   <= {cur_q[AxisZ], cur_q[AxisY], cur_q[AxisX]};
      out_motion_q <= moving_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_motion_q;

  // The divider only reports back while the sequencer waits for it.
  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  // Motion only stops at the end of an axis pass.
  a_stop_after_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(moving_q) |-> $past(state_q == S_AXACC))
    else $error("motion flag cleared outside an axis pass");

  // A move that ends leaves every axis exactly on its target.
  a_end_on_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && $past(state_q == S_AXACC) && !moving_q) |->
      (cur_q[AxisX] == aim_q[AxisX] && cur_q[AxisY] == aim_q[AxisY] &&
       cur_q[AxisZ] == aim_q[AxisZ]))
    else $error("finished move is not on its target");

endmodule

[sim/eased_position_tween_tb.sv]
// Self-checking testbench of the eased position tween, with stream drivers and a monitor.
// Predicts every result from its own copy of the axis state and the easing curves.
// Depends on eptw_pkg and the block's top level eased_position_tween.
`timescale 1ns / 100ps

module eased_position_tween_tb;
  import eptw_pkg::*;

  // Item kind that the block ignores, and the curve code that behaves as linear.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam int CYCLE_LIMIT = 1000000;
  // Cycles allowed for an item still in work once the last result has arrived.
  localparam int DRAIN_GAP   = 64;
  localparam int PHASE_ITEMS = 170;

  // One input transfer: the kind and the fields of tdata.
  typedef struct {
    logic [1:0]  func;
    logic [15:0] delta;
    logic [23:0] gx;
    logic [23:0] gy;
    logic [23:0] gz;
  } tween_cmd_t;

  // One output transfer.
  typedef struct {
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] pz;
    logic        moving;
  } tween_pos_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [15:0] cfg_data_i    = '0;

  eased_position_tween i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // tick_delta, goal_x, goal_y, goal_zoom
    .s_axis_tuser (s_axis_tuser),   // func
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // pos_x, pos_y, zoom_level
    .m_axis_tuser (m_axis_tuser),   // in_motion
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Items waiting to be offered, and the positions that the block should report.
  tween_cmd_t pending_items[$];
  tween_pos_t expected_pos[$];

  int issued_cnt   = 0;  // transfers put on the input bus by the driver
  int accepted_cnt = 0;  // transfers taken by the block
  int checked_cnt  = 0;
  int cycle_cnt    = 0;
  int mismatches   = 0;
  int idle_pct     = 29;
  int moves_done   = 0;
  int commands_seen = 0;
  int mode_ticks [4] = '{0, 0, 0, 0};

  // Predictor copy of the registers and of the axis state. Axis 0 is x, 1 is y, 2 is zoom.
  logic [15:0]        move_ticks;
  logic [1:0]         curve_sel;
  logic signed [23:0] cur_pos  [3];
  logic signed [23:0] base_pos [3];
  logic signed [23:0] aim_pos  [3];
  logic signed [24:0] span_pos [3];
  logic [15:0]        elapsed_ticks;
  logic               moving_now;
  logic [16:0]        sine_lut [SINE_TABLE_DEPTH + 1];

  // One table entry: a Q30 Taylor series of the sine up to the fifteenth power,
  // rounded half up to Q16 and clamped to one.
  function automatic logic [16:0] sine_lut_entry(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint unsigned q;
    x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = (longint'(acc) + 8192) >> 14;
    if (q > 65536) begin
      q = 65536;
    end
    return q[16:0];
  endfunction

  // Quarter sine of a Q1.16 angle, by linear interpolation between table entries.
  function automatic logic [16:0] quarter_sine(logic [16:0] q);
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    logic [16:0]     a;
    logic [16:0]     b;
    pos  = longint'(q) * SINE_TABLE_DEPTH;
    idx  = pos >> 16;
    frac = pos & 64'hFFFF;
    if (idx >= SINE_TABLE_DEPTH) begin
      return sine_lut[SINE_TABLE_DEPTH];
    end
    a = sine_lut[idx];
    b = sine_lut[idx + 1];
    if (b <= a) begin
      return a;
    end
    return a + 17'((longint'(b - a) * frac) >> 16);
  endfunction

  // A command restarts all three axes from where they stand now.
  function automatic void restart_axes();
    for (int i = 0; i < 3; i++) begin
      base_pos[i] = cur_pos[i];
      span_pos[i] = 25'(longint'(aim_pos[i]) - longint'(cur_pos[i]));
    end
    elapsed_ticks = '0;
    moving_now    = 1'b1;
    commands_seen++;
  endfunction

  // Applies one accepted item to the predictor and returns what the block should report.
  function automatic tween_pos_t predict_tween(tween_cmd_t c);
    tween_pos_t      r;
    logic [16:0]     sum;
    logic [16:0]     prog;
    logic [16:0]     f;
    longint          s;
    longint unsigned mag;
    longint unsigned prod;
    longint          off;
    case (c.func)
      FUNC_TICK: begin
        sum = {1'b0, elapsed_ticks} + {1'b0, c.delta};
        elapsed_ticks = sum[16] ? 16'hFFFF : sum[15:0];
        if (move_ticks == 0 || elapsed_ticks >= move_ticks) begin
          prog = ONE_Q16;
        end else begin
          prog = 17'(({elapsed_ticks, 16'h0000}) / move_ticks);
        end
        if (moving_now) begin
          mode_ticks[curve_sel]++;
          case (curve_sel)
            MODE_SINE:   f = quarter_sine(prog);
            MODE_COSINE: f = ONE_Q16 - quarter_sine(ONE_Q16 - prog);
            default:     f = prog;  // linear, and the spare code too
          endcase
          // Q1.16 times Q16.8, rounded to nearest with ties away from zero.
          for (int i = 0; i < 3; i++) begin
            s    = longint'(span_pos[i]);
            mag  = (s < 0) ? longint'(-s) : longint'(s);
            prod = (mag * longint'(f) + 32768) >> 16;
            off  = (s < 0) ? -longint'(prod) : longint'(prod);
            cur_pos[i] = 24'(longint'(base_pos[i]) + off);
          end
          if (prog == ONE_Q16) begin
            moving_now = 1'b0;
            moves_done++;
          end
        end
      end
      FUNC_SET_POS: begin
        aim_pos[0] = c.gx;
        aim_pos[1] = c.gy;
        restart_axes();
      end
      FUNC_SET_ZOOM: begin
        aim_pos[2] = c.gz;
        restart_axes();
      end
      default: ;  // the unused kind only reports the state
    endcase
    r.px     = cur_pos[0];
    r.py     = cur_pos[1];
    r.pz     = cur_pos[2];
    r.moving = moving_now;
    return r;
  endfunction

  function automatic void note_fault(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Input driver: offers the next pending item at a falling edge, holding it until taken.
  always @(negedge clk_i) begin : drive_input
    tween_cmd_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && accepted_cnt != issued_cnt)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.func;
        s_axis_tdata  <= {nxt.gz, nxt.gy, nxt.gx, nxt.delta};
        issued_cnt    <= issued_cnt + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The receiving side stalls at random too.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Monitor: checks each output transfer against the oldest prediction, then predicts
  // for an input transfer at the same edge.
  always @(posedge clk_i) begin : watch_streams
    tween_cmd_t c;
    tween_pos_t got;
    tween_pos_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.px     = m_axis_tdata[23:0];
        got.py     = m_axis_tdata[47:24];
        got.pz     = m_axis_tdata[71:48];
        got.moving = m_axis_tuser[0];
        if (expected_pos.size() == 0) begin
          note_fault($sformatf("result with nothing expected: x %h y %h zoom %h motion %b",
                               got.px, got.py, got.pz, got.moving));
        end else begin
          want = expected_pos.pop_front();
          checked_cnt++;
          if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
              got.moving !== want.moving) begin
            note_fault($sformatf({"result %0d: expected x %h y %h zoom %h motion %b, ",
                                  "got x %h y %h zoom %h motion %b"}, checked_cnt,
                                 want.px, want.py, want.pz, want.moving,
                                 got.px, got.py, got.pz, got.moving));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c.func  = s_axis_tuser;
        c.delta = s_axis_tdata[15:0];
        c.gx    = s_axis_tdata[39:16];
        c.gy    = s_axis_tdata[63:40];
        c.gz    = s_axis_tdata[87:64];
        expected_pos.push_back(predict_tween(c));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic queue_item(logic [1:0] func, logic [15:0] delta,
                            logic [23:0] gx, logic [23:0] gy, logic [23:0] gz);
    tween_cmd_t c;
    c.func  = func;
    c.delta = delta;
    c.gx    = gx;
    c.gy    = gy;
    c.gz    = gz;
    pending_items.push_back(c);
  endtask

  // A target, now and then at the ends of the range.
  function automatic logic [23:0] random_goal();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      default: return 24'($urandom());
    endcase
  endfunction

  // Register write at a falling edge; the predictor follows at once since the block is idle.
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_MOVE_DURATION) begin
      move_ticks = val;
    end else begin
      curve_sel = val[1:0];
    end
  endtask

  // Sender holds back until every prediction has been matched and the block is at rest.
  task automatic wait_drained();
    while (pending_items.size() != 0 || issued_cnt != accepted_cnt ||
           expected_pos.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Mostly whole moves: one or two commands, then ticks that step through the curve.
  // The rest is noise: unused kinds, ticks of any size, and commands cut short.
  task automatic queue_random_phase(int count, int unsigned dur);
    int          n;
    int unsigned lim;
    logic [1:0]  kind;
    lim = (dur < 8) ? 3 : dur / 4;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 78) begin
        kind = ($urandom_range(1) == 0) ? FUNC_SET_POS : FUNC_SET_ZOOM;
        queue_item(kind, 16'($urandom()), random_goal(), random_goal(), random_goal());
        n++;
        if ($urandom_range(2) == 0) begin
          kind = (kind == FUNC_SET_POS) ? FUNC_SET_ZOOM : FUNC_SET_POS;
          queue_item(kind, 16'($urandom()), random_goal(), random_goal(), random_goal());
          n++;
        end
        repeat ($urandom_range(2, 10)) begin
          queue_item(FUNC_TICK, 16'($urandom_range(0, lim)), 24'($urandom()),
                     24'($urandom()), 24'($urandom()));
          n++;
        end
        if ($urandom_range(1) == 0) begin
          queue_item(FUNC_TICK, 16'(dur), 24'($urandom()), 24'($urandom()),
                     24'($urandom()));
          n++;
        end
      end else begin
        case ($urandom_range(2))
          0:       queue_item(FUNC_UNUSED, 16'($urandom()), 24'($urandom()),
                              24'($urandom()), 24'($urandom()));
          1:       queue_item(FUNC_TICK, 16'($urandom()), 24'($urandom()),
                              24'($urandom()), 24'($urandom()));
          default: queue_item(FUNC_SET_POS, 16'($urandom()), random_goal(), random_goal(),
                              random_goal());
        endcase
        n++;
      end
    end
  endtask

  // Main sequence: reset, a directed opening and a random stretch at the reset settings, then
  // random phases that each begin with both registers written while the block is at rest.
  initial begin
    int unsigned dur_list  [8];
    logic [1:0]  mode_list [8];
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      sine_lut[k] = sine_lut_entry(k);
    end
    move_ticks    = DURATION_RESET;
    curve_sel     = MODE_RESET;
    elapsed_ticks = '0;
    moving_now    = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cur_pos[i]  = '0;
      base_pos[i] = '0;
      aim_pos[i]  = '0;
      span_pos[i] = '0;
    end
    dur_list  = '{1, 65535, 0, 7, 1000, $urandom_range(2, 5000), 250, 90};
    mode_list = '{MODE_SINE, MODE_COSINE, MODE_SINE, MODE_SPARE, MODE_COSINE, MODE_SINE,
                  MODE_LINEAR, MODE_SPARE};

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening. The motion flag is set out of reset with every span zero.
    queue_item(FUNC_UNUSED, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    queue_item(FUNC_TICK, 16'd0, '0, '0, '0);
    queue_item(FUNC_TICK, 16'd60, '0, '0, '0);                   // reaches the end
    queue_item(FUNC_TICK, 16'd5, '0, '0, '0);                    // tick while at rest
    queue_item(FUNC_SET_POS, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h123456);
    queue_item(FUNC_SET_ZOOM, 16'h0000, 24'h000000, 24'h000000, 24'h7FFFFF);
    queue_item(FUNC_TICK, 16'd15, '0, '0, '0);
    queue_item(FUNC_TICK, 16'd15, '0, '0, '0);
    queue_item(FUNC_TICK, 16'd30, '0, '0, '0);
    queue_item(FUNC_SET_POS, 16'd0, 24'h800000, 24'h7FFFFF, '0);  // widest spans
    queue_item(FUNC_SET_ZOOM, 16'd0, '0, '0, 24'h800000);
    queue_item(FUNC_TICK, 16'd1, '0, '0, '0);
    queue_item(FUNC_TICK, 16'hFFFF, '0, '0, '0);                 // elapsed saturates
    queue_item(FUNC_TICK, 16'hFFFF, '0, '0, '0);
    queue_item(FUNC_SET_POS, 16'd0, 24'h000000, 24'h000000, '0);
    queue_item(FUNC_TICK, 16'd30, '0, '0, '0);
    queue_item(FUNC_UNUSED, 16'd0, '0, '0, '0);                  // unused kind mid-move
    queue_item(FUNC_SET_ZOOM, 16'd0, '0, '0, 24'h000100);        // command mid-move
    queue_item(FUNC_TICK, 16'd59, '0, '0, '0);
    queue_item(FUNC_TICK, 16'd1, '0, '0, '0);
    wait_drained();

    // A stretch with neither side idling, still at the reset settings.
    idle_pct = 0;
    queue_random_phase(PHASE_ITEMS, DURATION_RESET);
    wait_drained();
    idle_pct = 29;

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_MOVE_DURATION, 16'(dur_list[ph]));
      // The upper bits of the curve write are noise that the block drops.
      write_reg(CFG_EASE_MODE, {14'($urandom()), mode_list[ph]});
      queue_random_phase(PHASE_ITEMS, dur_list[ph]);
      wait_drained();
    end

    $display("tb: %0d transfers in, %0d results checked, %0d commands, %0d moves ended",
             accepted_cnt, checked_cnt, commands_seen, moves_done);
    $display("tb: ticks in motion per curve: sine %0d, cosine %0d, linear %0d, spare %0d",
             mode_ticks[0], mode_ticks[1], mode_ticks[2], mode_ticks[3]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/eptw_pkg.sv
rtl/eptw_divider.sv
rtl/eptw_sine_rom.sv
rtl/eased_position_tween.sv
sim/eased_position_tween_tb.sv
